/* src/amgs_pkg.sv */
// Package for the adjacency matrix graph store: sizes, command codes and
// the item types shared by the front, the back and the top level.
// No dependencies.
`default_nettype none

package amgs_pkg;

  // Graph size and field widths
  localparam int NUM_VERTICES = 64;
  localparam int VERT_W       = 6;
  localparam int COUNT_W      = 7;
  localparam int ROW_ADDR_W   = $clog2(NUM_VERTICES);

  // Command queue between front and back
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [VERT_W:0] VERT_LIMIT = (VERT_W + 1)'(NUM_VERTICES);
  localparam logic [NUM_VERTICES-1:0] ROW_LSB = {{(NUM_VERTICES - 1){1'b0}}, 1'b1};

  // Command codes
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_LIST   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [VERT_W-1:0] vertex_a;
    logic [VERT_W-1:0] vertex_b;
  } in_item_t;

  typedef struct packed {
    logic               is_adjacent;
    logic [VERT_W-1:0]  neighbor;
    logic               neighbor_valid;
    logic [COUNT_W-1:0] neighbor_count;
    logic               last;
  } out_item_t;

  // Classified command as it waits in the queue
  typedef struct packed {
    logic [1:0]        op;
    logic [VERT_W-1:0] vertex_a;
    logic [VERT_W-1:0] vertex_b;
    logic              a_ok;
    logic              b_ok;
  } cmd_t;

  // Queue head as seen by the back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

endpackage

`default_nettype wire

/* src/amgs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module amgs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* src/amgs_front.sv */
// Front of the graph store: accepts commands, checks vertex ranges, drops
// the unused code and queues the rest for the back.
// Depends on amgs_pkg.
`default_nettype none

module amgs_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  amgs_pkg::in_item_t in_data,
  output amgs_pkg::qhead_t  head,
  input  logic              pop
);
  import amgs_pkg::*;

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  cmd_t              cmd_in;

  assign busy = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign push = start && !busy && (in_data.kind != KIND_UNUSED);

  // Classify: range flags travel with the command
  always_comb begin
    cmd_in.op       = in_data.kind;
    cmd_in.vertex_a = in_data.vertex_a;
    cmd_in.vertex_b = in_data.vertex_b;
    cmd_in.a_ok     = {1'b0, in_data.vertex_a} < VERT_LIMIT;
    cmd_in.b_ok     = {1'b0, in_data.vertex_b} < VERT_LIMIT;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.cmd   = slot_r[rd_ptr_r];

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("pop from empty command queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !push)
    else $error("push into full command queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("command queue count out of range");
`endif

endmodule

`default_nettype wire

/* src/amgs_back.sv */
// Back of the graph store: runs queued commands against the adjacency
// matrix RAM and drives the result strobe.
// Depends on amgs_pkg and amgs_ram.
`default_nettype none

module amgs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  amgs_pkg::qhead_t   head,
  output logic               pop,
  output logic               out_strobe,
  output amgs_pkg::out_item_t out_data
);
  import amgs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_WRB  = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  logic [1:0]              state_r, state_nxt;
  cmd_t                    cmd_r, cmd_nxt;
  logic [NUM_VERTICES-1:0] row_valid_r, row_valid_nxt;
  logic                    rd_valid_r, rd_valid_nxt;
  logic [NUM_VERTICES-1:0] rem_r, rem_nxt;
  logic [COUNT_W-1:0]      count_r, count_nxt;
  logic                    out_strobe_r, out_strobe_nxt;
  out_item_t               out_r, out_nxt;

  logic                    ram_we, ram_re;
  logic [ROW_ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [NUM_VERTICES-1:0] ram_wdata, ram_rdata;
  logic [NUM_VERTICES-1:0] row, lowest, rem_left;
  logic [ROW_ADDR_W-1:0]   a_idx, b_idx, head_a_idx, low_idx;

  function automatic logic [ROW_ADDR_W-1:0] onehot_idx(input logic [NUM_VERTICES-1:0] oh);
    logic [ROW_ADDR_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < NUM_VERTICES; i++) begin
      if (oh[i]) begin
        idx = idx | ROW_ADDR_W'(i);
      end
    end
    return idx;
  endfunction

  amgs_ram #(
    .WIDTH (NUM_VERTICES),
    .DEPTH (NUM_VERTICES)
  ) u_rows (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign a_idx      = cmd_r.vertex_a[ROW_ADDR_W-1:0];
  assign b_idx      = cmd_r.vertex_b[ROW_ADDR_W-1:0];
  assign head_a_idx = head.cmd.vertex_a[ROW_ADDR_W-1:0];

  // A row never written since reset reads as all zero
  assign row      = ram_rdata & {NUM_VERTICES{rd_valid_r}};
  assign lowest   = rem_r & (~rem_r + ROW_LSB);
  assign rem_left = rem_r & ~lowest;
  assign low_idx  = onehot_idx(lowest);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    row_valid_nxt  = row_valid_r;
    rd_valid_nxt   = rd_valid_r;
    rem_nxt        = rem_r;
    count_nxt      = count_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = '0;
    pop            = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = a_idx;
    ram_wdata      = row | (ROW_LSB << b_idx);
    ram_re         = 1'b0;
    ram_raddr      = head_a_idx;

    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop     = 1'b1;
          cmd_nxt = head.cmd;
          out_nxt.last = 1'b1;
          if (head.cmd.a_ok && (head.cmd.b_ok || head.cmd.op == KIND_LIST)) begin
            // Fetch row a, then carry on in S_EXEC
            ram_re       = 1'b1;
            rd_valid_nxt = row_valid_r[head_a_idx];
            state_nxt    = S_EXEC;
          end else begin
            // Out-of-range vertex: plain ack, zero answer or empty listing
            out_strobe_nxt = 1'b1;
          end
        end
      end

      S_EXEC: begin
        unique case (cmd_r.op)
          KIND_ADD: begin
            ram_we               = 1'b1;
            row_valid_nxt[a_idx] = 1'b1;
            if (a_idx == b_idx) begin
              out_strobe_nxt = 1'b1;
              out_nxt.last   = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              ram_re       = 1'b1;
              ram_raddr    = b_idx;
              rd_valid_nxt = row_valid_r[b_idx];
              state_nxt    = S_WRB;
            end
          end
          KIND_QUERY: begin
            out_strobe_nxt      = 1'b1;
            out_nxt.is_adjacent = row[b_idx];
            out_nxt.last        = 1'b1;
            state_nxt           = S_IDLE;
          end
          default: begin
            if (row == '0) begin
              out_strobe_nxt = 1'b1;
              out_nxt.last   = 1'b1;
              state_nxt      = S_IDLE;
            end else begin
              rem_nxt   = row;
              count_nxt = '0;
              state_nxt = S_SCAN;
            end
          end
        endcase
      end

      S_WRB: begin
        ram_we               = 1'b1;
        ram_waddr            = b_idx;
        ram_wdata            = row | (ROW_LSB << a_idx);
        row_valid_nxt[b_idx] = 1'b1;
        out_strobe_nxt       = 1'b1;
        out_nxt.last         = 1'b1;
        state_nxt            = S_IDLE;
      end

      default: begin
        // Emit lowest remaining neighbor and drop it from the row
        rem_nxt                = rem_left;
        count_nxt              = count_r + 1'b1;
        out_strobe_nxt         = 1'b1;
        out_nxt.neighbor       = VERT_W'(low_idx);
        out_nxt.neighbor_valid = 1'b1;
        out_nxt.neighbor_count = count_r + 1'b1;
        out_nxt.last           = (rem_left == '0);
        if (rem_left == '0) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      row_valid_r  <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      row_valid_r  <= row_valid_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    rd_valid_r <= rd_valid_nxt;
    rem_r      <= rem_nxt;
    count_r    <= count_nxt;
    out_r      <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> state_r == S_IDLE)
    else $error("command taken while back busy");

  a_scan_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> rem_r != '0)
    else $error("scan with empty row");

  a_scan_emits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |=> out_strobe_r)
    else $error("scan cycle without result");

  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_r.neighbor_valid |-> out_r.neighbor_count != '0)
    else $error("neighbor result with zero count");
`endif

endmodule

`default_nettype wire

/* src/adjacency_matrix_graph_store_unit.sv */
// Add edge and query give a single result; a listing gives one result per neighbor, one per cycle,
// or a single empty result for an empty row. The back takes the next queued command only when it
// is done with the last; add edge does two read-modify-writes of the row RAM (one for a self loop).
// The receiver cannot stall; busy rises only when the command queue is full.
// Reset (rst_n low, synchronous) empties the queue and marks every row all zero.
`default_nettype none

module adjacency_matrix_graph_store_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  // Command channel: transfer when start is high and busy is low
  input  logic                 start,
  output logic                 busy,
  input  amgs_pkg::in_item_t   in_data,
  // Result channel: one transfer per cycle in which out_strobe is high
  output logic                 out_strobe,
  output amgs_pkg::out_item_t  out_data
);
  import amgs_pkg::*;

  qhead_t head;
  logic   pop;

  // Front: range check, drop the unused code, queue the rest
  amgs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_data (in_data),
    .head    (head),
    .pop     (pop)
  );

  // Back: matrix RAM, row valid bits and the neighbor scan
  amgs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire
